// File: rtl/lfbd_pkg.sv
// ----------------------------------------------------------------------------
// lfbd_pkg
// Shared types and constants for the LZSS flag-byte decoder.
// ----------------------------------------------------------------------------
package lfbd_pkg;

    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int COUNT_WIDTH_DEF  = 24;

    localparam int CAP_W      = 24;
    localparam int TOTAL_W    = 24;
    localparam int DIST_W     = 12;
    localparam int LEN_W      = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 24'hFF_FFFF;
    localparam logic [3:0]       LEN_MASK  = 4'hF;
    localparam logic [LEN_W-1:0] LEN_BIAS  = 5'd3;
    localparam logic [3:0]       FLAG_DONE = 4'd8;

    // result kinds
    localparam logic [2:0] KIND_DATA  = 3'd0;
    localparam logic [2:0] KIND_OK    = 3'd1;
    localparam logic [2:0] KIND_CAP   = 3'd2;
    localparam logic [2:0] KIND_DIST  = 3'd3;
    localparam logic [2:0] KIND_TRUNC = 3'd4;

    // data part of a command
    localparam logic [1:0] DT_NONE = 2'd0;
    localparam logic [1:0] DT_LIT  = 2'd1;
    localparam logic [1:0] DT_COPY = 2'd2;

    // register map (byte addresses)
    localparam logic [2:0] ADDR_CAP = 3'd0;

    typedef struct packed {
        logic [1:0]        dtype;
        logic [7:0]        lit;
        logic [DIST_W-1:0] dist_m1;
        logic [LEN_W-1:0]  len;
        logic              has_end;
        logic [2:0]        end_kind;
    } t_cmd;

endpackage

// File: rtl/lfbd_if.sv
// ----------------------------------------------------------------------------
// lfbd_in_if / lfbd_out_if
// Valid/ready channels for compressed input bytes and decoded results.
// ----------------------------------------------------------------------------
interface lfbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_last;

    modport source (output valid, output in_byte, output stream_last, input ready);
    modport sink   (input valid, input in_byte, input stream_last, output ready);
endinterface

interface lfbd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [2:0]  kind;
    logic [23:0] total_count;
    logic        run_last;

    modport source (output valid, output out_byte, output kind, output total_count,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input kind, input total_count,
                    input run_last, output ready);
endinterface

// File: rtl/lfbd_front.sv
// ----------------------------------------------------------------------------
// lfbd_front
// Parses flag bytes, literals and tokens, checks capacity and distance, and
// turns each input byte into at most one command for the copy engine.
// ----------------------------------------------------------------------------
module lfbd_front
    import lfbd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lfbd_in_if.sink          i_in,
    input  logic [CAP_W-1:0] i_cap,
    input  logic             i_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    localparam int XW = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 1;

    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [7:0]             r_fbits, n_fbits;
    logic [3:0]             r_fidx, n_fidx;
    logic [7:0]             r_tlow, n_tlow;
    logic                   r_await, n_await;
    logic                   r_halted, n_halted;
    logic [2:0]             r_skind, n_skind;

    logic             accept;
    logic [XW-1:0]    cnt_x;
    logic [XW-1:0]    cap_x;
    logic [XW-1:0]    avail;
    logic [DIST_W:0]  tok_dist;
    logic [LEN_W-1:0] tok_len;
    logic [LEN_W-1:0] copy_n;
    t_cmd             cmd;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    assign cnt_x    = XW'(r_cnt);
    assign cap_x    = XW'(i_cap);
    assign avail    = cap_x - cnt_x;
    assign tok_dist = {1'b0, i_in.in_byte, r_tlow[7:4]} + (DIST_W+1)'(1);
    assign tok_len  = {1'b0, r_tlow[3:0] & LEN_MASK} + LEN_BIAS;
    assign copy_n   = (avail < XW'(tok_len)) ? avail[LEN_W-1:0] : tok_len;

    always_comb begin
        n_cnt    = r_cnt;
        n_fbits  = r_fbits;
        n_fidx   = r_fidx;
        n_tlow   = r_tlow;
        n_await  = r_await;
        n_halted = r_halted;
        n_skind  = r_skind;
        cmd          = '0;
        cmd.end_kind = KIND_OK;

        if (accept) begin
            if (!r_halted) begin
                if (r_fidx[3]) begin
                    n_fbits = i_in.in_byte;
                    n_fidx  = 4'd0;
                end else if (r_fbits[r_fidx[2:0]]) begin
                    n_fidx = r_fidx + 4'd1;
                    if (cnt_x >= cap_x) begin
                        n_halted = 1'b1;
                        n_skind  = KIND_CAP;
                    end else begin
                        cmd.dtype = DT_LIT;
                        cmd.lit   = i_in.in_byte;
                        n_cnt     = r_cnt + COUNT_WIDTH'(1);
                    end
                end else if (!r_await) begin
                    n_tlow  = i_in.in_byte;
                    n_await = 1'b1;
                    if (i_in.stream_last) begin
                        n_halted = 1'b1;
                        n_skind  = KIND_TRUNC;
                    end
                end else begin
                    n_await = 1'b0;
                    n_fidx  = r_fidx + 4'd1;
                    if (XW'(tok_dist) > cnt_x) begin
                        n_halted = 1'b1;
                        n_skind  = KIND_DIST;
                    end else begin
                        // clip the copy at capacity; part of it may still go out
                        if (cnt_x >= cap_x || copy_n != tok_len) begin
                            n_halted = 1'b1;
                            n_skind  = KIND_CAP;
                        end
                        if (cnt_x < cap_x) begin
                            cmd.dtype   = DT_COPY;
                            cmd.dist_m1 = {i_in.in_byte, r_tlow[7:4]};
                            cmd.len     = copy_n;
                            n_cnt       = r_cnt + COUNT_WIDTH'(copy_n);
                        end
                    end
                end
            end

            if (i_in.stream_last) begin
                cmd.has_end  = 1'b1;
                cmd.end_kind = n_halted ? n_skind : KIND_OK;
                n_cnt    = '0;
                n_fbits  = '0;
                n_fidx   = FLAG_DONE;
                n_tlow   = '0;
                n_await  = 1'b0;
                n_halted = 1'b0;
                n_skind  = KIND_OK;
            end
        end
    end

    assign o_push = accept && (cmd.dtype != DT_NONE || cmd.has_end);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_fbits  <= '0;
            r_fidx   <= FLAG_DONE;
            r_tlow   <= '0;
            r_await  <= 1'b0;
            r_halted <= 1'b0;
            r_skind  <= KIND_OK;
        end else begin
            r_cnt    <= n_cnt;
            r_fbits  <= n_fbits;
            r_fidx   <= n_fidx;
            r_tlow   <= n_tlow;
            r_await  <= n_await;
            r_halted <= n_halted;
            r_skind  <= n_skind;
        end
    end

endmodule

// File: rtl/lfbd_queue.sv
// ----------------------------------------------------------------------------
// lfbd_queue
// Short command FIFO between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lfbd_queue
    import lfbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int QAW = $clog2(QUEUE_DEPTH);

    t_cmd           r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QAW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QAW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/lfbd_back.sv
// ----------------------------------------------------------------------------
// lfbd_back
// Copy engine: plays out literals and back-references through the history
// window one byte a cycle within a command while o_out accepts, then the
// end-of-stream status, into an output register.
// ----------------------------------------------------------------------------
module lfbd_back
    import lfbd_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_empty,
    output logic        o_pop,
    lfbd_out_if.source  o_out
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [7:0] r_hist [WINDOW_DEPTH];

    // command being issued
    logic [LEN_W-1:0]  r_rem;
    logic              r_endp;
    logic              r_mem;
    logic [7:0]        r_lit;
    logic [DIST_W-1:0] r_dm1;
    logic [2:0]        r_ekind;
    logic [AW-1:0]     r_iptr;

    // read stage
    logic              r_s2v;
    logic [2:0]        r_s2_kind;
    logic              r_s2_mem;
    logic [7:0]        r_s2_byte;
    logic              r_s2_last;
    logic [7:0]        r_rdata;
    logic              r_byp;
    logic [7:0]        r_bypd;

    logic [COUNT_WIDTH-1:0] r_cnt;

    // output register
    logic         r_ov;
    logic [7:0]   r_obyte;
    logic [2:0]   r_okind;
    logic [TOTAL_W-1:0] r_ocnt;
    logic         r_olast;

    logic          busy;
    logic          s2_adv;
    logic          can_issue;
    logic          iss_data;
    logic          iss_end;
    logic          rd_en;
    logic [AW-1:0] raddr;
    logic          wr_en;
    logic [AW-1:0] waddr;
    logic [7:0]    s2_data;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    assign busy      = (r_rem != '0) || r_endp;
    assign o_pop     = !busy && !i_empty;
    assign s2_adv    = r_s2v && (!r_ov || o_out.ready);
    assign can_issue = !r_s2v || s2_adv;
    assign iss_data  = can_issue && (r_rem != '0);
    assign iss_end   = can_issue && (r_rem == '0) && r_endp;
    assign rd_en     = iss_data && r_mem;
    assign raddr     = r_iptr - AW'(r_dm1) - AW'(1);

    assign s2_data = (r_s2_kind != KIND_DATA) ? 8'd0 :
                     !r_s2_mem ? r_s2_byte :
                     r_byp     ? r_bypd    : r_rdata;
    assign wr_en   = s2_adv && (r_s2_kind == KIND_DATA);
    assign waddr   = r_cnt[AW-1:0];
    assign cnt_inc = r_cnt + COUNT_WIDTH'(1);

    // read-first history; a read that hits the byte written this cycle is bypassed
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist[waddr] <= s2_data;
        end
        if (rd_en) begin
            r_rdata <= r_hist[raddr];
            r_byp   <= wr_en && (waddr == raddr);
            r_bypd  <= s2_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mem   <= (i_cmd.dtype == DT_COPY);
            r_lit   <= i_cmd.lit;
            r_dm1   <= i_cmd.dist_m1;
            r_ekind <= i_cmd.end_kind;
        end
        if (can_issue) begin
            r_s2_kind <= iss_end ? r_ekind : KIND_DATA;
            r_s2_mem  <= r_mem;
            r_s2_byte <= r_lit;
            r_s2_last <= iss_end || ((r_rem == LEN_W'(1)) && !r_endp);
        end
        if (s2_adv) begin
            r_obyte <= s2_data;
            r_okind <= r_s2_kind;
            r_ocnt  <= (r_s2_kind == KIND_DATA) ? TOTAL_W'(cnt_inc) : TOTAL_W'(r_cnt);
            r_olast <= r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_endp <= 1'b0;
            r_iptr <= '0;
            r_s2v  <= 1'b0;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                unique case (i_cmd.dtype)
                    DT_LIT:  r_rem <= LEN_W'(1);
                    DT_COPY: r_rem <= i_cmd.len;
                    default: r_rem <= '0;
                endcase
                r_endp <= i_cmd.has_end;
            end else if (iss_data) begin
                r_rem <= r_rem - LEN_W'(1);
            end else if (iss_end) begin
                r_endp <= 1'b0;
            end

            if (iss_data) begin
                r_iptr <= r_iptr + AW'(1);
            end else if (iss_end) begin
                r_iptr <= '0;
            end

            if (can_issue) begin
                r_s2v <= iss_data || iss_end;
            end

            if (s2_adv) begin
                r_cnt <= (r_s2_kind == KIND_DATA) ? cnt_inc : '0;
            end

            if (s2_adv) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_byte    = r_obyte;
    assign o_out.kind        = r_okind;
    assign o_out.total_count = r_ocnt;
    assign o_out.run_last    = r_olast;

endmodule

// File: rtl/lzss_flag_byte_decoder.sv
// ----------------------------------------------------------------------------
// lzss_flag_byte_decoder
// LZSS decoder for flag-byte streams with 12-bit distance and 4-bit length.
// ----------------------------------------------------------------------------
// i_in carries one compressed byte per beat with stream_last on the final
// byte of a stream. o_out carries decoded bytes (kind data) and, after the
// last byte of a stream, one status beat with the final byte count; run_last
// marks the last beat caused by one input beat. The APB port holds the output
// capacity register at address 0 (reset 0xFFFFFF); pready is tied high.
// A parser takes an input beat every cycle while its 4-entry command queue
// has room. The copy engine drains the queue: it loads a command, then gives
// one result per cycle while o_out accepts (literal, each byte of a copy up
// to 18, or the status), limited by the single read port of the 4096-byte
// history memory. A literal passes the queue and the command, read and output
// registers; a long copy holds the queue, and input stalls once it fills.
// When o_out is stalled the output register holds its beat and the engine
// waits behind it. Reset clears all control state; the history memory is not
// cleared, as a copy only reads bytes written earlier in the same stream.
// ----------------------------------------------------------------------------
module lzss_flag_byte_decoder
    import lfbd_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfbd_in_if.sink     i_in,
    lfbd_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CAP_W-1:0] r_cap;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    t_cmd             w_cmd_in;
    t_cmd             w_cmd_out;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAP) ? 32'(r_cap) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_CAP) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    lfbd_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cap   (r_cap),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in)
    );

    lfbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    lfbd_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command pushed into a full queue");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command popped from an empty queue");

    a_status_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != KIND_DATA) |-> (o_out.run_last && o_out.out_byte == 8'd0))
        else $error("status beat without run_last or with a nonzero byte");

endmodule

// File: tb/lzss_flag_byte_decoder_tb.sv
// ----------------------------------------------------------------------------
// lzss_flag_byte_decoder_tb
// Self-checking bench for the LZSS flag-byte decoder.
// ----------------------------------------------------------------------------
// A short table of hand-built streams covers literal extremes, the longest
// overlapping copy, a token cut off by the end of a stream, a distance that
// reaches before the start of the output, a stream ending on a flag byte and
// capacity stops. Random streams follow: mostly well-formed ones with random
// content, plus truncated, bad-distance and noise streams, and one long
// stream made almost wholly of long copies. Every decoded beat is checked
// against an in-bench decoder. Both channels idle at random, the receiver
// holds off once for a long stretch, and the output capacity register is
// rewritten between phases.
// ----------------------------------------------------------------------------
module lzss_flag_byte_decoder_tb;
    import lfbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_AW        = $clog2(WINDOW_DEPTH_DEF);
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 32;
    localparam int PHASE_ITEMS   = 40;
    localparam int LONG_ELEMS    = 48;

    // stream shapes for the random part
    localparam int SHAPE_CLEAN   = 0;
    localparam int SHAPE_TRUNC   = 1;
    localparam int SHAPE_BADDIST = 2;
    localparam int SHAPE_NOISE   = 3;
    localparam int SHAPE_LONG    = 4;

    typedef struct packed {
        logic [7:0]         data;
        logic [2:0]         kind;
        logic [TOTAL_W-1:0] total;
        logic               last_of_item;
    } t_decoded_beat;

    typedef struct packed {
        logic               set_cap;
        logic [CAP_W-1:0]   cap;
        logic [7:0]         data;
        logic               last;
        logic               typed;
        logic [2:0]         kind;
        logic [TOTAL_W-1:0] total;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [26] = '{
        // flag: two literals, then tokens
        '{1'b0, 24'd0, 8'h03, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h00, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'hFF, 1'b0, 1'b0, KIND_DATA,  24'd0},
        // distance 1, length 18: overlapping copy
        '{1'b0, 24'd0, 8'h0F, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h00, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h10, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h00, 1'b0, 1'b0, KIND_DATA,  24'd0},
        // stream ends on a token low byte
        '{1'b0, 24'd0, 8'hA5, 1'b1, 1'b1, KIND_TRUNC, 24'd23},
        // distance 4096 with nothing produced, then ignored bytes
        '{1'b0, 24'd0, 8'h00, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'hFF, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'hFF, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h5A, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h11, 1'b1, 1'b1, KIND_DIST,  24'd0},
        // copy of 18 on the last byte: 19 beats from one input
        '{1'b0, 24'd0, 8'h01, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h80, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h0F, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h00, 1'b1, 1'b1, KIND_OK,    24'd19},
        // stream made of a lone flag byte
        '{1'b0, 24'd0, 8'h42, 1'b1, 1'b1, KIND_OK,    24'd0},
        // zero capacity
        '{1'b1, 24'd0, 8'hFF, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h33, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h44, 1'b1, 1'b1, KIND_CAP,   24'd0},
        // capacity 5 cuts a copy part way
        '{1'b1, 24'd5, 8'h01, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h7E, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h0F, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h00, 1'b0, 1'b0, KIND_DATA,  24'd0},
        '{1'b0, 24'd0, 8'h00, 1'b1, 1'b1, KIND_CAP,   24'd5}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lfbd_in_if  in_ch ();
    lfbd_out_if out_ch ();

    lzss_flag_byte_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // decoder state mirrored in the bench
    logic [7:0]         hist [WINDOW_DEPTH_DEF];
    logic [TOTAL_W-1:0] made_cnt;
    logic [7:0]         flags;
    logic [3:0]         flag_pos;
    logic [7:0]         tok_lo;
    logic               want_hi;
    logic               stopped;
    logic [2:0]         stop_code;
    logic [CAP_W-1:0]   cap_limit;

    t_decoded_beat decoded_q [$];
    logic [8:0]    stream_q [$];

    int errors      = 0;
    int in_beats    = 0;
    int streams     = 0;
    int data_beats  = 0;
    int cap_writes  = 0;
    int ends_by_kind [8];
    int quiet       = 0;
    bit in_calm     = 1'b0;

    function automatic int pick_gap(inout bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic void clear_stream();
        made_cnt  = '0;
        flags     = '0;
        flag_pos  = FLAG_DONE;
        tok_lo    = '0;
        want_hi   = 1'b0;
        stopped   = 1'b0;
        stop_code = KIND_OK;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic last);
        int                 n;
        int unsigned        back_dist;
        int unsigned        len;
        logic [15:0]        tok;
        logic [WIN_AW-1:0]  src;
        t_decoded_beat      tail;
        n = 0;
        if (!stopped) begin
            if (flag_pos >= FLAG_DONE) begin
                flags    = b;
                flag_pos = '0;
            end else if (flags[flag_pos[2:0]]) begin
                flag_pos++;
                if (made_cnt >= cap_limit) begin
                    stopped   = 1'b1;
                    stop_code = KIND_CAP;
                end else begin
                    hist[made_cnt[WIN_AW-1:0]] = b;
                    made_cnt++;
                    decoded_q.push_back('{b, KIND_DATA, made_cnt, 1'b0});
                    n++;
                end
            end else if (!want_hi) begin
                tok_lo  = b;
                want_hi = 1'b1;
                if (last) begin
                    stopped   = 1'b1;
                    stop_code = KIND_TRUNC;
                end
            end else begin
                tok       = {b, tok_lo};
                back_dist = int'(tok[15:4]) + 1;
                len       = int'(tok[3:0]) + LEN_BIAS;
                want_hi   = 1'b0;
                flag_pos++;
                if (back_dist > made_cnt) begin
                    stopped   = 1'b1;
                    stop_code = KIND_DIST;
                end else begin
                    for (int k = 0; k < len; k++) begin
                        if (made_cnt >= cap_limit) begin
                            stopped   = 1'b1;
                            stop_code = KIND_CAP;
                            break;
                        end
                        src = WIN_AW'(made_cnt - back_dist);
                        hist[made_cnt[WIN_AW-1:0]] = hist[src];
                        made_cnt++;
                        decoded_q.push_back('{hist[src], KIND_DATA, made_cnt, 1'b0});
                        n++;
                    end
                end
            end
        end
        if (last) begin
            decoded_q.push_back('{8'h00, stopped ? stop_code : KIND_OK, made_cnt, 1'b0});
            n++;
            streams++;
            clear_stream();
        end
        if (n > 0) begin
            tail = decoded_q.pop_back();
            tail.last_of_item = 1'b1;
            decoded_q.push_back(tail);
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap(in_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= b;
        in_ch.stream_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        in_beats++;
        decode_byte(b, last);
    endtask

    // drop valid and wait for every owed beat, then let the block go quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_rw(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_CAP;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] value);
        logic [31:0] rd;
        apb_rw(1'b1, 32'(value), rd);
        apb_rw(1'b0, 32'd0, rd);
        if (rd[CAP_W-1:0] !== value) begin
            errors++;
            $display("%0t: capacity read back expected %06h got %06h",
                     $time, value, rd[CAP_W-1:0]);
        end
        cap_limit = value;
        cap_writes++;
    endtask

    task automatic build_stream(input int shape);
        int          n_elem;
        int          placed;
        int          m;
        int          lit_pct;
        int          gcount;
        int          lim;
        int          d;
        int          len;
        int          r;
        bit          at_end;
        bit          bad;
        logic [7:0]  flag;
        logic [15:0] tok;
        logic [8:0]  grp [$];
        stream_q.delete();
        if (shape == SHAPE_NOISE) begin
            n_elem = $urandom_range(1, 12);
            repeat (n_elem) stream_q.push_back({1'b0, 8'($urandom)});
        end else begin
            n_elem  = (shape == SHAPE_LONG) ? LONG_ELEMS : $urandom_range(1, 24);
            lit_pct = (shape == SHAPE_LONG) ? 3 : 45;
            placed  = 0;
            gcount  = 0;
            while (placed < n_elem) begin
                m    = (n_elem - placed < 8) ? n_elem - placed : 8;
                flag = 8'($urandom);
                grp.delete();
                for (int j = 0; j < m; j++) begin
                    at_end = (placed + j == n_elem - 1);
                    bad    = at_end && shape == SHAPE_BADDIST && gcount < WINDOW_DEPTH_DEF;
                    if (at_end && shape == SHAPE_TRUNC) begin
                        // low byte only: the stream ends inside the token
                        flag[j] = 1'b0;
                        grp.push_back({1'b0, 8'($urandom)});
                    end else if (!bad && (gcount == 0 || $urandom_range(0, 99) < lit_pct)) begin
                        flag[j] = 1'b1;
                        grp.push_back({1'b0, 8'($urandom)});
                        gcount++;
                    end else begin
                        flag[j] = 1'b0;
                        if (bad) begin
                            d = $urandom_range(gcount + 1, WINDOW_DEPTH_DEF);
                        end else begin
                            lim = (gcount < WINDOW_DEPTH_DEF) ? gcount : WINDOW_DEPTH_DEF;
                            r   = $urandom_range(0, 3);
                            if (r == 0)
                                d = lim;
                            else if (r == 1)
                                d = $urandom_range(1, (lim < 4) ? lim : 4);
                            else
                                d = $urandom_range(1, lim);
                        end
                        r = $urandom_range(0, 7);
                        if ((shape == SHAPE_LONG && r != 0) || r == 1)
                            len = 18;
                        else if (r == 2)
                            len = 3;
                        else
                            len = $urandom_range(3, 18);
                        tok = 16'(((d - 1) << 4) | (len - LEN_BIAS));
                        grp.push_back({1'b0, tok[7:0]});
                        grp.push_back({1'b0, tok[15:8]});
                        gcount += len;
                    end
                end
                stream_q.push_back({1'b0, flag});
                foreach (grp[k]) stream_q.push_back(grp[k]);
                placed += m;
            end
            // bytes after a halt are ignored until the end of the stream
            if (shape == SHAPE_BADDIST)
                repeat ($urandom_range(0, 3)) stream_q.push_back({1'b0, 8'($urandom)});
            // end on a fresh flag byte now and then
            if (shape == SHAPE_CLEAN && placed % 8 == 0 && $urandom_range(0, 1) == 1)
                stream_q.push_back({1'b0, 8'($urandom)});
        end
        stream_q[stream_q.size() - 1][8] = 1'b1;
    endtask

    // receiver: random stalls, one long hold-off, and the check of each beat
    initial begin
        int            w;
        int            beats;
        bit            calm;
        t_decoded_beat got;
        t_decoded_beat want;
        out_ch.ready = 1'b0;
        beats        = 0;
        calm         = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            w = (beats == HOLD_AT) ? HOLD_CYCLES : pick_gap(calm);
            if (w > 0) begin
                out_ch.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            beats++;
            got = '{out_ch.out_byte, out_ch.kind, out_ch.total_count, out_ch.run_last};
            if (decoded_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat byte=%02h kind=%0d total=%0d last=%0b",
                         $time, got.data, got.kind, got.total, got.last_of_item);
            end else begin
                want = decoded_q.pop_front();
                if (got.data !== want.data) begin
                    errors++;
                    $display("%0t: out_byte expected %02h got %02h",
                             $time, want.data, got.data);
                end
                if (got.kind !== want.kind) begin
                    errors++;
                    $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
                end
                if (got.total !== want.total) begin
                    errors++;
                    $display("%0t: total_count expected %0d got %0d",
                             $time, want.total, got.total);
                end
                if (got.last_of_item !== want.last_of_item) begin
                    errors++;
                    $display("%0t: run_last expected %0b got %0b",
                             $time, want.last_of_item, got.last_of_item);
                end
                if (want.kind == KIND_DATA)
                    data_beats++;
                else
                    ends_by_kind[want.kind]++;
            end
        end
    end

    // count cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int               phase_items;
        int               shape;
        int               r;
        bit               paused;
        logic [31:0]      rd;
        logic [CAP_W-1:0] phase_cap [4];
        t_decoded_beat    tail;

        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.in_byte     = '0;
        in_ch.stream_last = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = ADDR_CAP;
        pwdata            = '0;
        paused            = 1'b0;
        cap_limit         = CAP_RESET;
        clear_stream();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_rw(1'b0, 32'd0, rd);
        if (rd[CAP_W-1:0] !== CAP_RESET) begin
            errors++;
            $display("%0t: capacity after reset expected %06h got %06h",
                     $time, CAP_RESET, rd[CAP_W-1:0]);
        end

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].set_cap) begin
                settle();
                set_capacity(DIR_ROWS[i].cap);
            end
            push_byte(DIR_ROWS[i].data, DIR_ROWS[i].last);
            if (DIR_ROWS[i].typed) begin
                // the status beat is known by hand for these rows
                tail       = decoded_q.pop_back();
                tail.data  = 8'h00;
                tail.kind  = DIR_ROWS[i].kind;
                tail.total = DIR_ROWS[i].total;
                decoded_q.push_back(tail);
            end
        end

        phase_cap[0] = CAP_W'($urandom_range(8, 60));
        phase_cap[1] = CAP_RESET;
        phase_cap[2] = CAP_W'($urandom_range(0, 24'hFF_FFFF));
        phase_cap[3] = CAP_W'($urandom_range(1, 200));

        for (int ph = 0; ph < 4; ph++) begin
            settle();
            set_capacity(phase_cap[ph]);
            if (ph == 1) begin
                // long stream of mostly full-length copies
                build_stream(SHAPE_LONG);
                foreach (stream_q[k]) push_byte(stream_q[k][7:0], stream_q[k][8]);
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if (ph == 2 && !paused && phase_items >= PHASE_ITEMS / 2) begin
                    settle();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 60)
                    shape = SHAPE_CLEAN;
                else if (r < 72)
                    shape = SHAPE_TRUNC;
                else if (r < 84)
                    shape = SHAPE_BADDIST;
                else
                    shape = SHAPE_NOISE;
                build_stream(shape);
                foreach (stream_q[k]) push_byte(stream_q[k][7:0], stream_q[k][8]);
                phase_items += stream_q.size();
            end
        end

        settle();

        $display("Run covered %0d input beats in %0d streams, %0d data beats, %0d capacity writes",
                 in_beats, streams, data_beats, cap_writes);
        $display("Stream ends: ok %0d, capacity %0d, bad distance %0d, truncated %0d",
                 ends_by_kind[KIND_OK], ends_by_kind[KIND_CAP],
                 ends_by_kind[KIND_DIST], ends_by_kind[KIND_TRUNC]);
        if (errors == 0 && decoded_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
